// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Each check samples on the rising clock edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every sampled edge.
`define AMF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("amf assertion failed");

// Expression must never be true at a sampled edge.
`define AMF_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("amf forbidden condition seen");

`else

`define AMF_ASSERT(label, clk, rst_n, prop)
`define AMF_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/amf_pkg.sv =====
package amf_pkg;

  localparam int unsigned MAX_ELEMENTS    = 256;
  localparam int unsigned IDX_W           = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W           = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned MODE_COUNT_W    = 9;
  localparam int unsigned COUNT_FIELD_MAX = 511;

  typedef logic signed [VALUE_W-1:0]      value_t;
  typedef logic [MODE_COUNT_W-1:0]        mode_count_t;
  typedef logic [CNT_W-1:0]               cnt_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic store;      // input transfer: write element or flag drop
    logic init_scan;  // reset outer index and best-so-far
    logic rd_outer;   // read candidate element i, rewind inner index
    logic latch;      // capture candidate, clear match counter
    logic rd_inner;   // read element j, advance j
    logic acc;        // compare read data with candidate
    logic update;     // fold match count into best, advance i
    logic publish;    // load result register, clear set state
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic inner_done;  // all elements of the inner pass have been read
    logic outer_last;  // current candidate is the last stored element
  } dp_status_t;

endpackage

// ===== hw/rtl/amf_in_if.sv =====
interface amf_in_if;
  logic                 valid;
  logic                 ready;
  amf_pkg::value_t      value;
  logic                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== hw/rtl/amf_out_if.sv =====
interface amf_out_if;
  logic                  valid;
  logic                  ready;
  amf_pkg::value_t       mode_value;
  amf_pkg::mode_count_t  mode_count;
  logic                  found;
  logic                  overflow;

  modport source (output valid, output mode_value, output mode_count, output found,
                  output overflow, input ready);
  modport sink   (input valid, input mode_value, input mode_count, input found,
                  input overflow, output ready);
endinterface

// ===== hw/rtl/amf_datapath.sv =====
`include "assert_macros.svh"

module amf_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  amf_pkg::dp_cmd_t      cmd_i,
  output amf_pkg::dp_status_t   status_o,
  input  amf_pkg::value_t       in_value_i,
  output amf_pkg::value_t       mode_value_o,
  output amf_pkg::mode_count_t  mode_count_o,
  output logic                  found_o,
  output logic                  overflow_o
);

  localparam int unsigned IdxW = amf_pkg::IDX_W;

  logic [amf_pkg::VALUE_W-1:0] mem [amf_pkg::MAX_ELEMENTS];

  amf_pkg::cnt_t    fill_q, fill_d;
  logic             dropped_q, dropped_d;
  amf_pkg::cnt_t    i_q, i_d;
  amf_pkg::cnt_t    j_q, j_d;
  amf_pkg::cnt_t    match_q, match_d;
  amf_pkg::cnt_t    best_q, best_d;
  amf_pkg::value_t  best_val_q;
  amf_pkg::value_t  cand_q;
  amf_pkg::value_t  rd_data_q;
  logic             full;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;

  amf_pkg::value_t       mode_value_q;
  amf_pkg::mode_count_t  mode_count_q;
  logic                  found_q;
  logic                  overflow_q;

  assign full    = (fill_q == amf_pkg::cnt_t'(amf_pkg::MAX_ELEMENTS));
  assign rd_en   = cmd_i.rd_outer | cmd_i.rd_inner;
  assign rd_addr = cmd_i.rd_outer ? i_q[IdxW-1:0] : j_q[IdxW-1:0];

  assign status_o.inner_done = (j_q == fill_q);
  assign status_o.outer_last = ((i_q + amf_pkg::cnt_t'(1)) == fill_q);

  // Element store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      mem[fill_q[IdxW-1:0]] <= in_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    fill_d    = fill_q;
    dropped_d = dropped_q;
    i_d       = i_q;
    j_d       = j_q;
    match_d   = match_q;
    best_d    = best_q;
    if (cmd_i.store) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        fill_d = fill_q + amf_pkg::cnt_t'(1);
      end
    end
    if (cmd_i.init_scan) begin
      i_d    = '0;
      best_d = '0;
    end
    if (cmd_i.rd_outer) begin
      j_d = '0;
    end
    if (cmd_i.latch) begin
      match_d = '0;
    end
    if (cmd_i.rd_inner) begin
      j_d = j_q + amf_pkg::cnt_t'(1);
    end
    if (cmd_i.acc && (rd_data_q == cand_q)) begin
      match_d = match_q + amf_pkg::cnt_t'(1);
    end
    if (cmd_i.update) begin
      i_d = i_q + amf_pkg::cnt_t'(1);
      // strict compare: earliest element keeps a tie
      if (match_q > best_q) begin
        best_d = match_q;
      end
    end
    if (cmd_i.publish) begin
      fill_d    = '0;
      dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      dropped_q <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      match_q   <= '0;
      best_q    <= '0;
    end else begin
      fill_q    <= fill_d;
      dropped_q <= dropped_d;
      i_q       <= i_d;
      j_q       <= j_d;
      match_q   <= match_d;
      best_q    <= best_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cand_q <= rd_data_q;
    end
    if (cmd_i.update && (match_q > best_q)) begin
      best_val_q <= cand_q;
    end
    if (cmd_i.publish) begin
      mode_value_q <= best_val_q;
      if (32'(best_q) > 32'(amf_pkg::COUNT_FIELD_MAX)) begin
        mode_count_q <= amf_pkg::mode_count_t'(amf_pkg::COUNT_FIELD_MAX);
      end else begin
        mode_count_q <= amf_pkg::mode_count_t'(best_q);
      end
      found_q    <= (best_q > amf_pkg::cnt_t'(1));
      overflow_q <= dropped_q;
    end
  end

  assign mode_value_o = mode_value_q;
  assign mode_count_o = mode_count_q;
  assign found_o      = found_q;
  assign overflow_o   = overflow_q;

  `AMF_ASSERT(a_fill_bounded, clk_i, rst_ni, fill_q <= amf_pkg::cnt_t'(amf_pkg::MAX_ELEMENTS))
  `AMF_ASSERT(a_acc_after_read, clk_i, rst_ni, cmd_i.acc |-> $past(cmd_i.rd_inner))
  `AMF_ASSERT(a_publish_clears, clk_i, rst_ni, cmd_i.publish |=> (fill_q == '0) && !dropped_q)

endmodule

// ===== hw/rtl/amf_ctrl.sv =====
`include "assert_macros.svh"

module amf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output amf_pkg::dp_cmd_t     cmd_o,
  input  amf_pkg::dp_status_t  status_i
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_LATCH,
    ST_INNER,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.store = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.init_scan = 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd_o.rd_outer = 1'b1;
        state_d = ST_LATCH;
      end
      ST_LATCH: begin
        cmd_o.latch    = 1'b1;
        cmd_o.rd_inner = 1'b1;
        state_d = ST_INNER;
      end
      ST_INNER: begin
        cmd_o.acc = 1'b1;
        if (status_i.inner_done) begin
          state_d = ST_UPDATE;
        end else begin
          cmd_o.rd_inner = 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = status_i.outer_last ? ST_EMIT : ST_FETCH;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `AMF_ASSERT(a_publish_slot_free, clk_i, rst_ni, cmd_o.publish |-> slot_free)
  `AMF_ASSERT(a_publish_sets_valid, clk_i, rst_ni, cmd_o.publish |=> out_valid_q)
  `AMF_ASSERT(a_last_starts_scan, clk_i, rst_ni, (in_valid_i && in_ready_o && in_last_i) |=> (state_q == ST_FETCH))
  `AMF_ASSERT_NEVER(a_no_store_in_scan, clk_i, rst_ni, cmd_o.store && (state_q != ST_LOAD))

endmodule

// ===== hw/rtl/array_mode_finder.sv =====
// Throughput: one element transfer per cycle while a set is loading.
// Scan: after the transfer that carries last, each stored element is fetched and
//   latched, then compared with every stored element through the single read port
//   of the element store, one compare per cycle, and folded into the best.
// Reset (rst_ni low, async): controller idles in load, fill/drop state clears;
//   the element store is not cleared and needs no clearing pass.

module array_mode_finder (
  input  logic        clk_i,
  input  logic        rst_ni,
  amf_in_if.sink      in_i,
  amf_out_if.source   out_o
);

  amf_pkg::dp_cmd_t     cmd;
  amf_pkg::dp_status_t  status;

  // Sequencer: load, then for each stored element count its matches
  // over the whole store, then hold the result until the sink takes it.
  amf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Element store, index counters, match/best registers and result register.
  amf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_value_i   (in_i.value),
    .mode_value_o (out_o.mode_value),
    .mode_count_o (out_o.mode_count),
    .found_o      (out_o.found),
    .overflow_o   (out_o.overflow)
  );

endmodule

// ===== verif/mode_result_checker.sv =====
`timescale 1ns / 1ps

module mode_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  amf_in_if    in_i,
  amf_out_if   out_i,
  output int   mismatches_o,
  output int   pending_o
);

  typedef struct {
    amf_pkg::value_t      mode_value;
    amf_pkg::mode_count_t mode_count;
    logic                 found;
    logic                 overflow;
  } mode_result_t;

  amf_pkg::value_t elems [amf_pkg::MAX_ELEMENTS];
  int unsigned     fill;
  logic            dropped;
  int              errors;
  mode_result_t    expected_modes [$];

  // Scan in arrival order; only a strictly higher count replaces the best.
  function automatic mode_result_t tally_mode();
    mode_result_t r;
    int unsigned  best;
    int unsigned  hits;
    best = 0;
    r.mode_value = '0;
    for (int unsigned i = 0; i < fill; i++) begin
      hits = 0;
      for (int unsigned j = 0; j < fill; j++) begin
        if (elems[j] == elems[i]) hits++;
      end
      if (hits > best) begin
        best = hits;
        r.mode_value = elems[i];
      end
    end
    r.mode_count = (best > amf_pkg::COUNT_FIELD_MAX)
                   ? amf_pkg::mode_count_t'(amf_pkg::COUNT_FIELD_MAX)
                   : amf_pkg::mode_count_t'(best);
    r.found = (best > 1);
    r.overflow = dropped;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [32:0] want,
                             input logic signed [32:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mode_result_t want;
    if (!rst_ni) begin
      fill = 0;
      dropped = 1'b0;
      errors = 0;
      expected_modes.delete();
      mismatches_o <= 0;
      pending_o <= 0;
    end else begin
      // result side first: a result at this edge belongs to an older set
      if (out_i.valid && out_i.ready) begin
        if (expected_modes.size() == 0) begin
          $error("mode_value: no result expected, actual %0d", out_i.mode_value);
          errors++;
        end else begin
          want = expected_modes.pop_front();
          check_field("mode_value", want.mode_value, out_i.mode_value);
          check_field("mode_count", want.mode_count, out_i.mode_count);
          check_field("found", want.found, out_i.found);
          check_field("overflow", want.overflow, out_i.overflow);
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (fill < amf_pkg::MAX_ELEMENTS) begin
          elems[fill] = in_i.value;
          fill++;
        end else begin
          dropped = 1'b1;
        end
        if (in_i.last) begin
          expected_modes.push_back(tally_mode());
          fill = 0;
          dropped = 1'b0;
        end
      end
      mismatches_o <= errors;
      pending_o <= expected_modes.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Content styles for random sets: the narrow ones force repeats and ties.
  typedef enum int {
    NEAR_ZERO,
    FEW_WORDS,
    ANY_WORD,
    EDGE_WORDS
  } fill_kind_e;

  localparam int ITEM_TARGET = 1300;
  localparam int LARGE_SETS  = 3;
  localparam int DRAIN_TAIL  = 300;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  int   items_sent;
  logic steady;

  amf_in_if  in_ch ();
  amf_out_if out_ch ();

  array_mode_finder uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Predicts every set's mode from the observed transfers and scores results.
  mode_result_checker watch (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One set, last raised on the final element. valid stays high across
  // back-to-back transfers; it is only dropped when a gap follows.
  task automatic send_batch(input amf_pkg::value_t vals[$]);
    int gap;
    for (int k = 0; k < vals.size(); k++) begin
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.value <= vals[k];
      in_ch.last  <= (k == vals.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      items_sent++;
    end
  endtask

  // Hold off the sender until every set sent so far has its result back.
  // The first edge lets the checker's count catch up with the last transfer.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: ready bursts of random length, random stalls between them,
  // and an occasional long stretch of steady ready.
  initial begin
    int hold;
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                          : $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    amf_pkg::value_t batch [$];
    amf_pkg::value_t pool [4];
    amf_pkg::value_t edges [4];
    fill_kind_e      kind;
    int              size;
    int              r;
    int              nsets;
    int              nlarge;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last = 1'b0;
    steady = 1'b0;
    items_sent = 0;
    nsets = 0;
    nlarge = 0;
    edges[0] = 32'h8000_0000;
    edges[1] = 32'h7fff_ffff;
    edges[2] = 32'h0000_0000;
    edges[3] = 32'hffff_ffff;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed sets ---
    // single element at each extreme: count 1, not found
    batch = '{32'h8000_0000};
    send_batch(batch);
    batch = '{32'h7fff_ffff};
    send_batch(batch);
    // extremes tied at two each: earliest wins
    batch = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
    send_batch(batch);
    // every element the same
    batch = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
    send_batch(batch);
    // all distinct: first element, count 1
    batch = '{32'd5, -32'sd5, 32'd0};
    send_batch(batch);
    // a later value with a strictly higher count takes over
    batch = '{32'd1, 32'd2, 32'd2, 32'd3, 32'd3, 32'd3};
    send_batch(batch);
    // tie where the earlier value closes its pair last
    batch = '{32'd7, 32'd8, 32'd8, 32'd7};
    send_batch(batch);
    wait_drained();

    // --- random sets ---
    // Mostly short sets; three big ones fill the store exactly and past capacity,
    // the two past capacity with the closing element itself dropped.
    while (items_sent < ITEM_TARGET) begin
      nsets++;
      if (nlarge < LARGE_SETS && nsets % 20 == 7) begin
        size = (nlarge == 0) ? amf_pkg::MAX_ELEMENTS :
               (nlarge == 1) ? amf_pkg::MAX_ELEMENTS + 1 :
                               $urandom_range(amf_pkg::MAX_ELEMENTS + 2,
                                              amf_pkg::MAX_ELEMENTS + 14);
        nlarge++;
        wait_drained();
      end else begin
        r = $urandom_range(0, 99);
        size = (r < 70) ? $urandom_range(1, 8) :
               (r < 92) ? $urandom_range(9, 24) : $urandom_range(25, 64);
      end
      kind = fill_kind_e'($urandom_range(0, 3));
      for (int i = 0; i < 4; i++) pool[i] = $urandom;
      steady = (nsets % 10 == 3);
      batch.delete();
      for (int k = 0; k < size; k++) begin
        case (kind)
          NEAR_ZERO:  batch.push_back(amf_pkg::value_t'($urandom_range(0, 7)) - 4);
          FEW_WORDS:  batch.push_back(pool[$urandom_range(0, 3)]);
          ANY_WORD:   batch.push_back(amf_pkg::value_t'($urandom));
          EDGE_WORDS: batch.push_back(edges[$urandom_range(0, 3)]);
          default:    batch.push_back('0);
        endcase
      end
      send_batch(batch);
      if (nsets % 9 == 0) wait_drained();
    end

    // Drain, then give a stray extra result a chance to show up.
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run.
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/amf_pkg.sv
hw/rtl/amf_in_if.sv
hw/rtl/amf_out_if.sv
hw/rtl/amf_datapath.sv
hw/rtl/amf_ctrl.sv
hw/rtl/array_mode_finder.sv
verif/mode_result_checker.sv
verif/tb.sv
